### rtl/core/rrqs_pkg.sv
package rrqs_pkg;

    localparam int ID_W   = 8;
    localparam int TIME_W = 12;
    localparam int EV_W   = 3;

    localparam logic [EV_W-1:0] EV_ACCEPTED  = 3'd0;
    localparam logic [EV_W-1:0] EV_REJECTED  = 3'd1;
    localparam logic [EV_W-1:0] EV_COMPLETED = 3'd2;
    localparam logic [EV_W-1:0] EV_REQUEUED  = 3'd3;
    localparam logic [EV_W-1:0] EV_HELD      = 3'd4;
    localparam logic [EV_W-1:0] EV_IDLE      = 3'd5;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    localparam logic [TIME_W-1:0] QUANTUM_RESET = 12'd50;

    // two-slot queues between the parts
    localparam logic [1:0] SLOTS_FULL = 2'd2;

    typedef struct packed {
        logic              is_tick;
        logic [ID_W-1:0]   job_id;
        logic [TIME_W-1:0] job_time;
    } cmd_t;

    typedef struct packed {
        logic [EV_W-1:0]   event_res;
        logic [ID_W-1:0]   served_id;
        logic [TIME_W-1:0] time_given;
        logic [TIME_W-1:0] time_left;
        logic              last;
    } res_t;

endpackage

### rtl/core/round_robin_quantum_scheduler.sv
// Round-robin time-slice scheduler over a FIFO of QUEUE_DEPTH jobs.
// Input channel (push/full): opcode 0 enqueues job_id/job_time, opcode 1
// runs one scheduling tick. Requests land in a two-slot command queue.
// Result channel (empty/pop): one result per enqueue, one per served job
// on a tick (idle result when nothing is served); last marks the final
// result of each request. Results wait in a two-slot output queue.
// Config channel (cfg_valid/cfg_ready/cfg_data): writes the quantum;
// cfg_ready is always high. Write it only while the block is idle.
// Path: a request passes through the command queue, the sequencer and
// the output queue before its result is on the result ports. The
// execution sequencer handles one request at a time: an enqueue is
// answered at once, a tick has a dispatch step into ST_TICK and then
// issues its results (at most QUEUE_DEPTH + 2), each served job read
// from the job store, whose head read is registered, with the last
// write forwarded.
// Reset: queue empty, no held credit, quantum 50; job store not cleared.
// Stall: when pop stays low the output queue fills, the sequencer holds,
// the command queue fills and full rises; nothing is dropped.
module round_robin_quantum_scheduler #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic                        opcode,
    input  logic [rrqs_pkg::ID_W-1:0]   job_id,
    input  logic [rrqs_pkg::TIME_W-1:0] job_time,
    output logic                        empty,
    input  logic                        pop,
    output logic [rrqs_pkg::EV_W-1:0]   event_res,
    output logic [rrqs_pkg::ID_W-1:0]   served_id,
    output logic [rrqs_pkg::TIME_W-1:0] time_given,
    output logic [rrqs_pkg::TIME_W-1:0] time_left,
    output logic                        last,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [rrqs_pkg::TIME_W-1:0] cfg_data
);

    logic [rrqs_pkg::TIME_W-1:0] quantum_reg;
    logic                        cmd_valid;
    logic                        cmd_pop;
    rrqs_pkg::cmd_t              cmd;
    logic                        res_room;
    logic                        res_push;
    rrqs_pkg::res_t              res;
    rrqs_pkg::res_t              res_out;

    // accept config writes at any time
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg <= rrqs_pkg::QUANTUM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            quantum_reg <= cfg_data;
        end
    end

    // front: take and classify requests
    rrqs_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .opcode    (opcode),
        .job_id    (job_id),
        .job_time  (job_time),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .cmd       (cmd)
    );

    // back: job store and tick sequencer
    rrqs_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .quantum   (quantum_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_room  (res_room),
        .res_push  (res_push),
        .res       (res)
    );

    // output queue decouples the sequencer from the receiver
    rrqs_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_in   (res),
        .res_room (res_room),
        .empty    (empty),
        .pop      (pop),
        .res_out  (res_out)
    );

    assign event_res  = res_out.event_res;
    assign served_id  = res_out.served_id;
    assign time_given = res_out.time_given;
    assign time_left  = res_out.time_left;
    assign last       = res_out.last;

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> res_room)
        else $error("result pushed into a full output queue");

    a_pop_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command popped from an empty command queue");

    a_idle_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && event_res == rrqs_pkg::EV_IDLE) |-> last)
        else $error("idle result not marked last");

    a_enq_single: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (event_res == rrqs_pkg::EV_ACCEPTED
                    || event_res == rrqs_pkg::EV_REJECTED))
        |-> (last && time_given == '0))
        else $error("enqueue result malformed");

endmodule

### rtl/core/rrqs_front.sv
module rrqs_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic                       opcode,
    input  logic [rrqs_pkg::ID_W-1:0]  job_id,
    input  logic [rrqs_pkg::TIME_W-1:0] job_time,
    output logic                       cmd_valid,
    input  logic                       cmd_pop,
    output rrqs_pkg::cmd_t             cmd
);

    rrqs_pkg::cmd_t slot_reg [2];
    logic           wp_reg;
    logic           wp_next;
    logic           rp_reg;
    logic           rp_next;
    logic [1:0]     cnt_reg;
    logic [1:0]     cnt_next;
    logic           take;
    rrqs_pkg::cmd_t incoming;

    assign full      = (cnt_reg == rrqs_pkg::SLOTS_FULL);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = slot_reg[rp_reg];
    assign take      = push && !full;

    // classify the request on the way in
    always_comb
    begin
        incoming.is_tick  = (opcode == rrqs_pkg::OP_TICK);
        incoming.job_id   = job_id;
        incoming.job_time = job_time;
    end

    always_comb
    begin
        wp_next  = take ? ~wp_reg : wp_reg;
        rp_next  = cmd_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg;
        if (take && !cmd_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!take && cmd_pop)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            slot_reg[wp_reg] <= incoming;
        end
    end

endmodule

### rtl/core/rrqs_back.sv
module rrqs_back #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [rrqs_pkg::TIME_W-1:0] quantum,
    input  logic                        cmd_valid,
    input  rrqs_pkg::cmd_t              cmd,
    output logic                        cmd_pop,
    input  logic                        res_room,
    output logic                        res_push,
    output rrqs_pkg::res_t              res
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int OW = $clog2(QUEUE_DEPTH + 1);
    localparam int NW = $clog2(QUEUE_DEPTH + 3);
    localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);
    localparam logic [OW-1:0] DEPTH_OCC = OW'(QUEUE_DEPTH);
    localparam logic [NW-1:0] MAX_RES   = NW'(QUEUE_DEPTH + 2);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_TICK = 2'b10
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    logic [PW-1:0]               head_reg;
    logic [PW-1:0]               head_next;
    logic [PW-1:0]               tail_reg;
    logic [PW-1:0]               tail_next;
    logic [OW-1:0]               occ_reg;
    logic [OW-1:0]               occ_next;
    logic [rrqs_pkg::TIME_W-1:0] credit_reg;
    logic [rrqs_pkg::TIME_W-1:0] credit_next;
    logic [rrqs_pkg::TIME_W-1:0] rem_reg;
    logic [rrqs_pkg::TIME_W-1:0] rem_next;
    logic [NW-1:0]               cnt_reg;
    logic [NW-1:0]               cnt_next;

    logic [rrqs_pkg::ID_W-1:0]   ids_mem   [QUEUE_DEPTH];
    logic [rrqs_pkg::TIME_W-1:0] times_mem [QUEUE_DEPTH];
    logic [rrqs_pkg::ID_W-1:0]   rd_id_reg;
    logic [rrqs_pkg::TIME_W-1:0] rd_time_reg;
    logic                        byp_reg;
    logic [rrqs_pkg::ID_W-1:0]   byp_id_reg;
    logic [rrqs_pkg::TIME_W-1:0] byp_time_reg;

    logic                        do_pop;
    logic                        do_push;
    logic                        do_hold;
    logic                        wr_en;
    logic [PW-1:0]               wr_addr;
    logic [rrqs_pkg::ID_W-1:0]   wr_id;
    logic [rrqs_pkg::TIME_W-1:0] wr_time;
    logic [PW-1:0]               rd_addr;

    logic [rrqs_pkg::ID_W-1:0]   cur_id;
    logic [rrqs_pkg::TIME_W-1:0] cur_time;
    logic [rrqs_pkg::TIME_W-1:0] rest;
    logic [rrqs_pkg::TIME_W-1:0] give_a;
    logic [rrqs_pkg::TIME_W-1:0] give_held;
    logic [rrqs_pkg::TIME_W-1:0] left_held;
    logic [rrqs_pkg::TIME_W-1:0] left_cut;

    function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + 1'b1;
    endfunction

    // head entry as of this cycle, with the last write forwarded
    assign cur_id   = byp_reg ? byp_id_reg : rd_id_reg;
    assign cur_time = byp_reg ? byp_time_reg : rd_time_reg;

    assign rest      = (quantum > credit_reg) ? quantum - credit_reg : '0;
    assign give_a    = (cur_time <= rest) ? cur_time : rest;
    assign give_held = (give_a <= rem_reg) ? give_a : rem_reg;
    assign left_held = cur_time - give_held;
    assign left_cut  = cur_time - rem_reg;

    always_comb
    begin
        state_next  = state_reg;
        credit_next = credit_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        do_pop      = 1'b0;
        do_push     = 1'b0;
        do_hold     = 1'b0;
        wr_id       = cur_id;
        wr_time     = cur_time;
        cmd_pop     = 1'b0;
        res_push    = 1'b0;
        res         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && res_room)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.is_tick)
                    begin
                        state_next = ST_TICK;
                        rem_next   = quantum;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        res_push       = 1'b1;
                        res.served_id  = cmd.job_id;
                        res.time_left  = cmd.job_time;
                        res.last       = 1'b1;
                        if (occ_reg == DEPTH_OCC)
                        begin
                            res.event_res = rrqs_pkg::EV_REJECTED;
                        end
                        else
                        begin
                            res.event_res = rrqs_pkg::EV_ACCEPTED;
                            do_push       = 1'b1;
                            wr_id         = cmd.job_id;
                            wr_time       = cmd.job_time;
                        end
                    end
                end
            end
            ST_TICK:
            begin
                if (res_room)
                begin
                    res_push = 1'b1;
                    if (rem_reg == '0 || occ_reg == '0)
                    begin
                        res.event_res = rrqs_pkg::EV_IDLE;
                        res.last      = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        res.served_id = cur_id;
                        cnt_next      = cnt_reg + 1'b1;
                        if (credit_reg != '0)
                        begin
                            // held job: finish the rest of its slice
                            res.time_given = give_held;
                            res.time_left  = left_held;
                            rem_next       = rem_reg - give_held;
                            credit_next    = '0;
                            do_pop         = 1'b1;
                            if (left_held == '0)
                            begin
                                res.event_res = rrqs_pkg::EV_COMPLETED;
                            end
                            else
                            begin
                                res.event_res = rrqs_pkg::EV_REQUEUED;
                                do_push       = 1'b1;
                                wr_time       = left_held;
                            end
                        end
                        else if (cur_time <= rem_reg)
                        begin
                            res.event_res  = rrqs_pkg::EV_COMPLETED;
                            res.time_given = cur_time;
                            rem_next       = rem_reg - cur_time;
                            do_pop         = 1'b1;
                        end
                        else
                        begin
                            res.time_given = rem_reg;
                            res.time_left  = left_cut;
                            rem_next       = '0;
                            wr_time        = left_cut;
                            if (rem_reg == quantum)
                            begin
                                res.event_res = rrqs_pkg::EV_REQUEUED;
                                do_pop        = 1'b1;
                                do_push       = 1'b1;
                            end
                            else
                            begin
                                res.event_res = rrqs_pkg::EV_HELD;
                                do_hold       = 1'b1;
                                credit_next   = rem_reg;
                            end
                        end
                        res.last = (rem_next == '0)
                                || (do_pop && !do_push && occ_reg == OW'(1))
                                || ((cnt_reg + 1'b1) == MAX_RES);
                        if (res.last)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        head_next = do_pop ? nxt(head_reg) : head_reg;
        tail_next = do_push ? nxt(tail_reg) : tail_reg;
        occ_next  = occ_reg;
        if (do_pop && !do_push)
        begin
            occ_next = occ_reg - 1'b1;
        end
        else if (do_push && !do_pop)
        begin
            occ_next = occ_reg + 1'b1;
        end
        wr_en   = do_push || do_hold;
        wr_addr = do_hold ? head_reg : tail_reg;
        rd_addr = head_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            head_reg   <= '0;
            tail_reg   <= '0;
            occ_reg    <= '0;
            credit_reg <= '0;
            rem_reg    <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            occ_reg    <= occ_next;
            credit_reg <= credit_next;
            rem_reg    <= rem_next;
            cnt_reg    <= cnt_next;
        end
    end

    // job store: one write port, head read registered each cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ids_mem[wr_addr]   <= wr_id;
            times_mem[wr_addr] <= wr_time;
        end
        rd_id_reg    <= ids_mem[rd_addr];
        rd_time_reg  <= times_mem[rd_addr];
        byp_reg      <= wr_en && (wr_addr == rd_addr);
        byp_id_reg   <= wr_id;
        byp_time_reg <= wr_time;
    end

endmodule

### rtl/core/rrqs_outq.sv
module rrqs_outq (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           res_push,
    input  rrqs_pkg::res_t res_in,
    output logic           res_room,
    output logic           empty,
    input  logic           pop,
    output rrqs_pkg::res_t res_out
);

    rrqs_pkg::res_t slot_reg [2];
    logic           wp_reg;
    logic           wp_next;
    logic           rp_reg;
    logic           rp_next;
    logic [1:0]     cnt_reg;
    logic [1:0]     cnt_next;
    logic           take;
    logic           give;

    assign res_room = (cnt_reg != rrqs_pkg::SLOTS_FULL);
    assign empty    = (cnt_reg == 2'd0);
    assign res_out  = slot_reg[rp_reg];
    assign take     = res_push && res_room;
    assign give     = pop && !empty;

    always_comb
    begin
        wp_next  = take ? ~wp_reg : wp_reg;
        rp_next  = give ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg;
        if (take && !give)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (!take && give)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            slot_reg[wp_reg] <= res_in;
        end
    end

endmodule
